// ===== hw/rtl/i2c_interrupt_event_sequencer_macros.svh =====
// Assertion helpers used by i2c_interrupt_event_sequencer. Clock and reset names are fixed: clk, arst_n.
`ifndef I2C_INTERRUPT_EVENT_SEQUENCER_MACROS_SVH
`define I2C_INTERRUPT_EVENT_SEQUENCER_MACROS_SVH

// same-cycle implication
`define I2CIES_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("i2cies assertion failed");

// next-cycle implication
`define I2CIES_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("i2cies assertion failed");

`endif

// ===== hw/rtl/i2cies_pkg.sv =====
package i2cies_pkg;

	localparam int unsigned TX_DEPTH_DEF = 64;

	typedef enum logic [2:0] {
		OP_EVENT    = 3'd0,
		OP_ERROR    = 3'd1,
		OP_TX_LOAD  = 3'd2,
		OP_RD_BEGIN = 3'd3,
		OP_WR_BEGIN = 3'd4
	} op_t;

	// status_one bit positions
	localparam int unsigned SR1_SB    = 0;
	localparam int unsigned SR1_ADDR  = 1;
	localparam int unsigned SR1_BTF   = 2;
	localparam int unsigned SR1_STOPF = 4;
	localparam int unsigned SR1_RXNE  = 6;
	localparam int unsigned SR1_TXE   = 7;
	localparam int unsigned SR1_BERR  = 8;
	localparam int unsigned SR1_ARLO  = 9;
	localparam int unsigned SR1_AF    = 10;
	localparam int unsigned SR1_OVR   = 11;

	localparam logic [15:0] CLR_NONE = 16'hFFFF;
	localparam logic [15:0] CLR_AF   = 16'hFBFF;
	localparam logic [15:0] CLR_ARLO = 16'hFDFF;
	localparam logic [15:0] CLR_BERR = 16'hFEFF;
	localparam logic [15:0] CLR_OVR  = 16'hF7FF;

	typedef struct packed {
		logic        dr_write_en;
		logic [7:0]  dr_write_byte;
		logic        start_request;
		logic        stop_request;
		logic        ack_clear;
		logic        pe_set;
		logic        buf_irq_disable;
		logic        evt_irq_disable;
		logic [1:0]  received_count;
		logic [7:0]  received_first;
		logic [7:0]  received_second;
		logic [15:0] status_clear_mask;
	} res_t;

endpackage

// ===== hw/rtl/i2cies_in_if.sv =====
interface i2cies_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [15:0] status_one;
	logic [15:0] status_two;
	logic [7:0]  data_in;
	logic [7:0]  data_in_second;
	logic [7:0]  tx_byte;
	logic [7:0]  byte_count;
	logic [7:0]  target_address;

	modport source (
		output valid, opcode, status_one, status_two, data_in, data_in_second,
			tx_byte, byte_count, target_address,
		input ready
	);
	modport sink (
		input valid, opcode, status_one, status_two, data_in, data_in_second,
			tx_byte, byte_count, target_address,
		output ready
	);
endinterface

// ===== hw/rtl/i2cies_out_if.sv =====
interface i2cies_out_if;
	logic        valid;
	logic        ready;
	logic        dr_write_en;
	logic [7:0]  dr_write_byte;
	logic        start_request;
	logic        stop_request;
	logic        ack_clear;
	logic        pe_set;
	logic        buf_irq_disable;
	logic        evt_irq_disable;
	logic [1:0]  received_count;
	logic [7:0]  received_first;
	logic [7:0]  received_second;
	logic [15:0] status_clear_mask;

	modport source (
		output valid, dr_write_en, dr_write_byte, start_request, stop_request, ack_clear,
			pe_set, buf_irq_disable, evt_irq_disable, received_count, received_first,
			received_second, status_clear_mask,
		input ready
	);
	modport sink (
		input valid, dr_write_en, dr_write_byte, start_request, stop_request, ack_clear,
			pe_set, buf_irq_disable, evt_irq_disable, received_count, received_first,
			received_second, status_clear_mask,
		output ready
	);
endinterface

// ===== hw/rtl/i2c_interrupt_event_sequencer.sv =====
// channel  dir  modport       words
// req      in   in_if.sink    one command / interrupt snapshot per word
// rsp      out  out_if.source one action word per accepted req word
//
// Two register stages: input register (_s1), then result register. One word per cycle while rsp is not stalled.
// An accepted req word passes the input register, then the result register, to rsp.
// Transmit queue lives in a RAM; its read port is aimed at the next head every cycle,
// with a bypass for a load into the slot being read, so the front byte is ready for a pop.
// rsp stall backs up into the input register, then deasserts req.ready.
// arst_n clears control state and queue pointers; queue contents are not cleared.
`include "i2c_interrupt_event_sequencer_macros.svh"

module i2c_interrupt_event_sequencer #(
	parameter int unsigned TX_DEPTH = i2cies_pkg::TX_DEPTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	i2cies_in_if.sink  req,
	i2cies_out_if.source rsp
);
	import i2cies_pkg::*;

	localparam int unsigned AW = $clog2(TX_DEPTH);
	localparam int unsigned FW = $clog2(TX_DEPTH + 1);

	// input stage
	logic        valid_s1;
	op_t         opcode_s1;
	logic [15:0] status_one_s1;
	logic [15:0] status_two_s1;
	logic [7:0]  data_in_s1;
	logic [7:0]  data_in_second_s1;
	logic [7:0]  tx_byte_s1;
	logic [7:0]  byte_count_s1;
	logic [7:0]  target_address_s1;

	// result stage
	logic out_valid_q;
	res_t out_q;

	// driver state
	logic          direction_rx_q;
	logic [7:0]    address_byte_q;
	logic [7:0]    total_bytes_q;
	logic [7:0]    bytes_left_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [FW-1:0] fill_q;

	logic          byp_q;
	logic [7:0]    byp_data_q;
	logic [7:0]    ram_rdata;

	logic          adv;
	logic          in_fire;
	res_t          res;
	logic          pop;
	logic          push;
	logic          pop_do;
	logic          push_do;
	logic          q_empty;
	logic          q_full;
	logic [7:0]    front;
	logic [AW-1:0] head_inc;
	logic [AW-1:0] tail_inc;
	logic [AW-1:0] head_d;
	logic [7:0]    left_d;
	logic [7:0]    left_dec1;
	logic [7:0]    left_dec2;
	logic          master;

	assign adv     = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv;
	assign in_fire = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			opcode_s1         <= op_t'(req.opcode);
			status_one_s1     <= req.status_one;
			status_two_s1     <= req.status_two;
			data_in_s1        <= req.data_in;
			data_in_second_s1 <= req.data_in_second;
			tx_byte_s1        <= req.tx_byte;
			byte_count_s1     <= req.byte_count;
			target_address_s1 <= req.target_address;
		end
	end

	// queue front: RAM read data, or the word loaded into that slot last cycle; zero when empty
	assign q_empty  = (fill_q == '0);
	assign q_full   = (fill_q == FW'(TX_DEPTH));
	assign front    = q_empty ? 8'h00 : (byp_q ? byp_data_q : ram_rdata);
	assign head_inc = (head_q == AW'(TX_DEPTH - 1)) ? '0 : head_q + AW'(1);
	assign tail_inc = (tail_q == AW'(TX_DEPTH - 1)) ? '0 : tail_q + AW'(1);
	assign master   = status_two_s1[0];

	assign left_dec1 = (bytes_left_q == 8'd0) ? 8'd0 : bytes_left_q - 8'd1;
	assign left_dec2 = (bytes_left_q < 8'd2) ? 8'd0 : bytes_left_q - 8'd2;

	always_comb begin
		res = '0;
		res.status_clear_mask = CLR_NONE;
		pop    = 1'b0;
		push   = 1'b0;
		left_d = bytes_left_q;
		unique case (opcode_s1)
			OP_EVENT: begin
				priority if (!master && status_one_s1[SR1_ADDR]) begin
					res = res;
				end else if (!master && status_one_s1[SR1_TXE]) begin
					res.dr_write_en   = 1'b1;
					res.dr_write_byte = front;
					pop = 1'b1;
				end else if (!master && status_one_s1[SR1_RXNE]) begin
					res.received_count = 2'd1;
					res.received_first = data_in_s1;
				end else if (!master && status_one_s1[SR1_STOPF]) begin
					res.pe_set = 1'b1;
				end else if (status_one_s1[SR1_SB]) begin
					res.dr_write_en   = 1'b1;
					res.dr_write_byte = address_byte_q;
				end else if (!master) begin
					res = res;
				end else if (status_one_s1[SR1_ADDR]) begin
					if (!direction_rx_q) begin
						res.dr_write_en     = 1'b1;
						res.dr_write_byte   = front;
						res.buf_irq_disable = (fill_q <= FW'(1));
						pop = 1'b1;
					end else if (total_bytes_q == 8'd2) begin
						res.ack_clear = 1'b1;
					end else if (total_bytes_q == 8'd1) begin
						res.ack_clear    = 1'b1;
						res.stop_request = 1'b1;
					end
				end else if (status_one_s1[SR1_TXE] && !status_one_s1[SR1_BTF]) begin
					if (!q_empty) begin
						res.dr_write_en     = 1'b1;
						res.dr_write_byte   = front;
						res.buf_irq_disable = (fill_q == FW'(1));
						pop = 1'b1;
					end
				end else if (status_one_s1[SR1_TXE]) begin
					res.stop_request    = 1'b1;
					res.evt_irq_disable = 1'b1;
				end else if (status_one_s1[SR1_RXNE]) begin
					if (total_bytes_q == 8'd2) begin
						res.ack_clear       = 1'b1;
						res.stop_request    = 1'b1;
						res.received_count  = 2'd2;
						res.received_first  = data_in_s1;
						res.received_second = data_in_second_s1;
						left_d = left_dec2;
					end else begin
						res.received_count = 2'd1;
						res.received_first = data_in_s1;
						left_d = left_dec1;
						if (left_dec1 == 8'd1) begin
							res.ack_clear    = 1'b1;
							res.stop_request = 1'b1;
						end
					end
				end else begin
					res = res;
				end
			end
			OP_ERROR: begin
				priority if (status_one_s1[SR1_AF]) begin
					res.status_clear_mask = CLR_AF;
				end else if (status_one_s1[SR1_ARLO]) begin
					res.status_clear_mask = CLR_ARLO;
				end else if (status_one_s1[SR1_BERR]) begin
					res.status_clear_mask = CLR_BERR;
				end else if (status_one_s1[SR1_OVR]) begin
					res.status_clear_mask = CLR_OVR;
				end else begin
					res.status_clear_mask = CLR_NONE;
				end
			end
			OP_TX_LOAD: begin
				push = 1'b1;
			end
			OP_RD_BEGIN: begin
				res.start_request = 1'b1;
				left_d = byte_count_s1;
			end
			OP_WR_BEGIN: begin
				res.start_request = 1'b1;
			end
			default: begin
				res = res;
			end
		endcase
	end

	assign pop_do  = adv && pop && !q_empty;
	assign push_do = adv && push && !q_full;
	assign head_d  = pop_do ? head_inc : head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_rx_q <= 1'b0;
			address_byte_q <= 8'h00;
			total_bytes_q  <= 8'h00;
			bytes_left_q   <= 8'h00;
			head_q         <= '0;
			tail_q         <= '0;
			fill_q         <= '0;
			byp_q          <= 1'b0;
		end else begin
			byp_q <= push_do && (tail_q == head_d);
			if (adv) begin
				bytes_left_q <= left_d;
				if (opcode_s1 == OP_RD_BEGIN) begin
					direction_rx_q <= 1'b1;
					address_byte_q <= {target_address_s1[7:1], 1'b1};
					total_bytes_q  <= byte_count_s1;
				end else if (opcode_s1 == OP_WR_BEGIN) begin
					direction_rx_q <= 1'b0;
					address_byte_q <= {target_address_s1[7:1], 1'b0};
				end
			end
			head_q <= head_d;
			if (push_do) begin
				tail_q <= tail_inc;
			end
			if (push_do) begin
				fill_q <= fill_q + FW'(1);
			end else if (pop_do) begin
				fill_q <= fill_q - FW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= tx_byte_s1;
	end

	i2cies_ram #(
		.WIDTH (8),
		.DEPTH (TX_DEPTH)
	) u_txq_ram (
		.clk   (clk),
		.we    (push_do),
		.waddr (tail_q),
		.wdata (tx_byte_s1),
		.raddr (head_d),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

	assign rsp.valid             = out_valid_q;
	assign rsp.dr_write_en       = out_q.dr_write_en;
	assign rsp.dr_write_byte     = out_q.dr_write_byte;
	assign rsp.start_request     = out_q.start_request;
	assign rsp.stop_request      = out_q.stop_request;
	assign rsp.ack_clear         = out_q.ack_clear;
	assign rsp.pe_set            = out_q.pe_set;
	assign rsp.buf_irq_disable   = out_q.buf_irq_disable;
	assign rsp.evt_irq_disable   = out_q.evt_irq_disable;
	assign rsp.received_count    = out_q.received_count;
	assign rsp.received_first    = out_q.received_first;
	assign rsp.received_second   = out_q.received_second;
	assign rsp.status_clear_mask = out_q.status_clear_mask;

	`I2CIES_ASSERT_NOW(a_fill_range, 1'b1, fill_q <= FW'(TX_DEPTH))
	`I2CIES_ASSERT_NOW(a_ptr_gap, (!q_empty && !q_full), head_q != tail_q)
	`I2CIES_ASSERT_NEXT(a_pop_dec, pop_do, fill_q == $past(fill_q) - FW'(1))
	`I2CIES_ASSERT_NEXT(a_push_inc, push_do, fill_q == $past(fill_q) + FW'(1))

endmodule

// ===== hw/rtl/i2cies_ram.sv =====
module i2cies_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== dv/tb_top.sv =====
module tb_top;
	import i2cies_pkg::*;

	localparam int unsigned QUEUE_DEPTH = TX_DEPTH_DEF;

	localparam logic [15:0] F_SB    = 16'(1 << SR1_SB);
	localparam logic [15:0] F_ADDR  = 16'(1 << SR1_ADDR);
	localparam logic [15:0] F_BTF   = 16'(1 << SR1_BTF);
	localparam logic [15:0] F_STOPF = 16'(1 << SR1_STOPF);
	localparam logic [15:0] F_RXNE  = 16'(1 << SR1_RXNE);
	localparam logic [15:0] F_TXE   = 16'(1 << SR1_TXE);
	localparam logic [15:0] F_BERR  = 16'(1 << SR1_BERR);
	localparam logic [15:0] F_ARLO  = 16'(1 << SR1_ARLO);
	localparam logic [15:0] F_AF    = 16'(1 << SR1_AF);
	localparam logic [15:0] F_OVR   = 16'(1 << SR1_OVR);
	localparam logic [15:0] F_EVENT_BITS = F_SB | F_ADDR | F_BTF | F_STOPF | F_RXNE | F_TXE;
	// status_one bits that the event decoder never looks at
	localparam logic [15:0] F_DONT_CARE = 16'hFF28;

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] s1;
		logic [15:0] s2;
		logic [7:0]  d1;
		logic [7:0]  d2;
		logic [7:0]  txb;
		logic [7:0]  cnt;
		logic [7:0]  addr;
	} cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic drv_valid = 1'b0;
	cmd_t drv_cmd = '0;
	logic sink_ready = 1'b0;

	i2cies_in_if  req_if();
	i2cies_out_if rsp_if();

	assign req_if.valid          = drv_valid;
	assign req_if.opcode         = drv_cmd.op;
	assign req_if.status_one     = drv_cmd.s1;
	assign req_if.status_two     = drv_cmd.s2;
	assign req_if.data_in        = drv_cmd.d1;
	assign req_if.data_in_second = drv_cmd.d2;
	assign req_if.tx_byte        = drv_cmd.txb;
	assign req_if.byte_count     = drv_cmd.cnt;
	assign req_if.target_address = drv_cmd.addr;
	assign rsp_if.ready          = sink_ready;

	i2c_interrupt_event_sequencer #(.TX_DEPTH(QUEUE_DEPTH)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	cmd_t cmd_q[$];
	res_t action_q[$];
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned n_made = 0;
	int unsigned n_fail = 0;

	// predictor state
	logic       dir_rx = 1'b0;
	logic [7:0] addr_reg = '0;
	logic [7:0] total_bytes = '0;
	logic [7:0] bytes_left = '0;
	logic [7:0] tx_fifo[$];

	function automatic logic [7:0] tx_pop();
		if (tx_fifo.size() == 0)
			return 8'h00;
		return tx_fifo.pop_front();
	endfunction

	function automatic void left_dec();
		if (bytes_left != 0)
			bytes_left = bytes_left - 8'd1;
	endfunction

	function automatic res_t event_action(cmd_t c);
		res_t r;
		logic master;
		r = '0;
		r.status_clear_mask = CLR_NONE;
		master = c.s2[0];
		if (!master) begin
			if (c.s1[SR1_ADDR])
				return r;
			if (c.s1[SR1_TXE]) begin
				r.dr_write_en = 1'b1;
				r.dr_write_byte = tx_pop();
				return r;
			end
			if (c.s1[SR1_RXNE]) begin
				r.received_count = 2'd1;
				r.received_first = c.d1;
				return r;
			end
			if (c.s1[SR1_STOPF]) begin
				r.pe_set = 1'b1;
				return r;
			end
		end
		if (c.s1[SR1_SB]) begin
			r.dr_write_en = 1'b1;
			r.dr_write_byte = addr_reg;
			return r;
		end
		if (!master)
			return r;
		if (c.s1[SR1_ADDR]) begin
			if (!dir_rx) begin
				r.dr_write_en = 1'b1;
				r.dr_write_byte = tx_pop();
				r.buf_irq_disable = (tx_fifo.size() == 0);
			end else if (total_bytes == 8'd2) begin
				r.ack_clear = 1'b1;
			end else if (total_bytes == 8'd1) begin
				r.ack_clear = 1'b1;
				r.stop_request = 1'b1;
			end
			return r;
		end
		if (c.s1[SR1_TXE] && !c.s1[SR1_BTF]) begin
			if (tx_fifo.size() != 0) begin
				r.dr_write_en = 1'b1;
				r.dr_write_byte = tx_pop();
				r.buf_irq_disable = (tx_fifo.size() == 0);
			end
			return r;
		end
		if (c.s1[SR1_TXE] && c.s1[SR1_BTF]) begin
			r.stop_request = 1'b1;
			r.evt_irq_disable = 1'b1;
			return r;
		end
		if (c.s1[SR1_RXNE]) begin
			if (total_bytes == 8'd2) begin
				r.ack_clear = 1'b1;
				r.stop_request = 1'b1;
				r.received_count = 2'd2;
				r.received_first = c.d1;
				r.received_second = c.d2;
				left_dec();
				left_dec();
			end else begin
				r.received_count = 2'd1;
				r.received_first = c.d1;
				left_dec();
				if (bytes_left == 8'd1) begin
					r.ack_clear = 1'b1;
					r.stop_request = 1'b1;
				end
			end
		end
		return r;
	endfunction

	function automatic res_t predict_action(cmd_t c);
		res_t r;
		r = '0;
		r.status_clear_mask = CLR_NONE;
		case (c.op)
			OP_EVENT: r = event_action(c);
			OP_ERROR: begin
				if (c.s1[SR1_AF])
					r.status_clear_mask = CLR_AF;
				else if (c.s1[SR1_ARLO])
					r.status_clear_mask = CLR_ARLO;
				else if (c.s1[SR1_BERR])
					r.status_clear_mask = CLR_BERR;
				else if (c.s1[SR1_OVR])
					r.status_clear_mask = CLR_OVR;
			end
			OP_TX_LOAD: begin
				// full queue drops the byte
				if (tx_fifo.size() < QUEUE_DEPTH)
					tx_fifo.push_back(c.txb);
			end
			OP_RD_BEGIN: begin
				dir_rx = 1'b1;
				addr_reg = {c.addr[7:1], 1'b1};
				total_bytes = c.cnt;
				bytes_left = c.cnt;
				r.start_request = 1'b1;
			end
			OP_WR_BEGIN: begin
				dir_rx = 1'b0;
				addr_reg = {c.addr[7:1], 1'b0};
				r.start_request = 1'b1;
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic string show(res_t r);
		return $sformatf({"wen=%0b wb=%02h start=%0b stop=%0b ack=%0b pe=%0b bufdis=%0b ",
			"evtdis=%0b rcnt=%0d r1=%02h r2=%02h mask=%04h"},
			r.dr_write_en, r.dr_write_byte, r.start_request, r.stop_request, r.ack_clear,
			r.pe_set, r.buf_irq_disable, r.evt_irq_disable, r.received_count,
			r.received_first, r.received_second, r.status_clear_mask);
	endfunction

	// driver: a word is taken when valid and ready are both high at the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (drv_valid && req_if.ready)
				action_q.push_back(predict_action(drv_cmd));
			if (!drv_valid || req_if.ready) begin
				if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					drv_cmd <= cmd_q.pop_front();
					drv_valid <= 1'b1;
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n) begin
			if (rsp_if.valid && sink_ready) begin
				got = {rsp_if.dr_write_en, rsp_if.dr_write_byte, rsp_if.start_request,
					rsp_if.stop_request, rsp_if.ack_clear, rsp_if.pe_set,
					rsp_if.buf_irq_disable, rsp_if.evt_irq_disable, rsp_if.received_count,
					rsp_if.received_first, rsp_if.received_second, rsp_if.status_clear_mask};
				if (action_q.size() == 0) begin
					if (n_fail < 10)
						$display("unexpected word: got %s", show(got));
					n_fail++;
				end else begin
					want = action_q.pop_front();
					if (got !== want) begin
						if (n_fail < 10)
							$display("mismatch:\n  exp %s\n  got %s", show(want), show(got));
						n_fail++;
					end
				end
			end
			sink_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic cmd_t noise_cmd();
		cmd_t c;
		c.op = 3'($urandom_range(7));
		c.s1 = 16'($urandom);
		c.s2 = 16'($urandom);
		c.d1 = 8'($urandom);
		c.d2 = 8'($urandom);
		c.txb = 8'($urandom);
		c.cnt = 8'($urandom);
		c.addr = 8'($urandom);
		return c;
	endfunction

	function automatic cmd_t event_cmd(logic master, logic [15:0] flags);
		cmd_t c;
		c = noise_cmd();
		c.op = OP_EVENT;
		c.s1 = (c.s1 & F_DONT_CARE) | flags;
		c.s2 = {c.s2[15:1], master};
		return c;
	endfunction

	function automatic cmd_t err_cmd(logic [15:0] s1);
		cmd_t c;
		c = noise_cmd();
		c.op = OP_ERROR;
		c.s1 = s1;
		return c;
	endfunction

	function automatic cmd_t load_cmd(logic [7:0] b);
		cmd_t c;
		c = noise_cmd();
		c.op = OP_TX_LOAD;
		c.txb = b;
		return c;
	endfunction

	function automatic cmd_t rd_cmd(logic [7:0] cnt, logic [7:0] addr);
		cmd_t c;
		c = noise_cmd();
		c.op = OP_RD_BEGIN;
		c.cnt = cnt;
		c.addr = addr;
		return c;
	endfunction

	function automatic cmd_t wr_cmd(logic [7:0] addr);
		cmd_t c;
		c = noise_cmd();
		c.op = OP_WR_BEGIN;
		c.addr = addr;
		return c;
	endfunction

	task automatic add(cmd_t c);
		cmd_q.push_back(c);
		if (c.op <= OP_WR_BEGIN)
			n_made++;
	endtask

	task automatic master_write(int unsigned loads, int unsigned pops);
		repeat (loads) add(load_cmd(8'($urandom)));
		add(wr_cmd(8'($urandom)));
		add(event_cmd(1'b1, F_SB));
		add(event_cmd(1'b1, F_ADDR));
		repeat (pops) add(event_cmd(1'b1, F_TXE));
		add(event_cmd(1'b1, F_TXE | F_BTF));
	endtask

	task automatic queue_scenario();
		int unsigned kind;
		int unsigned k;
		int unsigned pick;
		logic [7:0] cnt;
		logic [15:0] errs[4];
		kind = $urandom_range(99);
		errs = '{F_AF, F_ARLO, F_BERR, F_OVR};
		if (kind < 30) begin
			k = $urandom_range(6);
			master_write(k, $urandom_range(k + 1));
		end else if (kind < 60) begin
			pick = $urandom_range(19);
			if (pick == 0)
				cnt = 8'd0;
			else if (pick == 1)
				cnt = 8'($urandom);
			else
				cnt = 8'($urandom_range(6, 1));
			add(rd_cmd(cnt, 8'($urandom)));
			add(event_cmd(1'b1, F_SB));
			add(event_cmd(1'b1, F_ADDR));
			k = (cnt > 8 ? 8 : cnt) + $urandom_range(1);
			repeat (k) add(event_cmd(1'b1, F_RXNE | ($urandom_range(1) ? F_BTF : 16'h0)));
		end else if (kind < 75) begin
			repeat ($urandom_range(5, 1)) begin
				case ($urandom_range(5))
					0: add(event_cmd(1'b0, F_ADDR));
					1: add(event_cmd(1'b0, F_TXE));
					2: add(event_cmd(1'b0, F_RXNE));
					3: add(event_cmd(1'b0, F_STOPF));
					default: add(event_cmd(1'b0, 16'($urandom) & F_EVENT_BITS));
				endcase
			end
		end else if (kind < 85) begin
			if ($urandom_range(1))
				add(err_cmd((16'($urandom) & 16'hF0FF) | errs[$urandom_range(3)]));
			else
				add(err_cmd(16'($urandom)));
		end else if (kind < 92) begin
			repeat ($urandom_range(4, 1)) add(load_cmd(8'($urandom)));
		end else if (kind < 96) begin
			add(event_cmd(1'b1, 16'($urandom) & F_EVENT_BITS));
		end else begin
			add(noise_cmd());
		end
	endtask

	task automatic wait_drained();
		while (cmd_q.size() != 0 || drv_valid || action_q.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		cmd_t c;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 24;
		recv_idle_pct = 82;
		c = '0;
		c.op = OP_EVENT;
		add(c);
		add(event_cmd(1'b0, F_TXE));	// pop from empty queue reads 0
		add(event_cmd(1'b1, F_ADDR));
		add(err_cmd(16'h0000));
		add(err_cmd(16'hFFFF));
		add(err_cmd(F_ARLO | F_BERR | F_OVR));
		add(err_cmd(F_BERR | F_OVR));
		add(err_cmd(F_OVR));
		add(load_cmd(8'hFF));
		add(load_cmd(8'h00));
		add(wr_cmd(8'hFF));
		c = '1;
		c.op = OP_EVENT;
		add(c);
		add(event_cmd(1'b1, F_ADDR));
		add(event_cmd(1'b1, F_TXE));
		add(event_cmd(1'b1, F_TXE));
		add(event_cmd(1'b1, F_TXE | F_BTF));
		add(rd_cmd(8'd2, 8'h00));
		add(event_cmd(1'b1, F_ADDR));
		c = event_cmd(1'b1, F_RXNE);
		c.d1 = 8'hFF;
		c.d2 = 8'h00;
		add(c);
		add(rd_cmd(8'd1, 8'hAA));
		add(event_cmd(1'b1, F_ADDR));
		add(event_cmd(1'b1, F_RXNE));
		add(rd_cmd(8'd0, 8'h55));
		add(event_cmd(1'b1, F_RXNE));	// remaining count stays at 0
		add(event_cmd(1'b0, F_RXNE));
		add(event_cmd(1'b0, F_STOPF));
		c = '1;
		add(c);

		n_made = 0;
		while (n_made < 150)
			queue_scenario();
		wait_drained();

		send_idle_pct = 82;
		recv_idle_pct = 24;
		n_made = 0;
		// overfill the transmit queue, then drain it past empty
		repeat (QUEUE_DEPTH + 4) add(load_cmd(8'($urandom)));
		master_write(0, QUEUE_DEPTH + 1);
		while (n_made < 150)
			queue_scenario();
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		n_made = 0;
		while (n_made < 150)
			queue_scenario();
		wait_drained();

		repeat (10) @(posedge clk);
		if (n_fail == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/i2cies_pkg.sv
hw/rtl/i2cies_in_if.sv
hw/rtl/i2cies_out_if.sv
hw/rtl/i2cies_ram.sv
hw/rtl/i2c_interrupt_event_sequencer.sv
dv/tb_top.sv
